// ----- src/mrr_pkg.sv -----
// Shared types and constants for the Modbus RTU reply receiver.
`timescale 1ns / 1ps

package mrr_pkg;

  // Input action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [1:0] REG_CMD_CODE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  // Register reset values
  localparam logic [7:0]  DEV_ADDR_RST = 8'd1;
  localparam logic [7:0]  CMD_CODE_RST = 8'd3;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  // CRC-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Address, function code, byte count and two CRC bytes
  localparam int unsigned FRAME_OVERHEAD = 5;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CRC   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_RD_HI = 7'b0001000,
    S_RD_LO = 7'b0010000,
    S_LOAD  = 7'b0100000,
    S_PUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        word_valid;
    logic [15:0] reply_word;
    logic        last;
  } result_t;

endpackage

// ----- src/modbus_rtu_reply_receiver.sv -----
// Start and non-timeout ticks are handled in S_IDLE; a timeout tick also passes through S_PUT.
// A stored byte passes accept, 8 CRC bit steps on one shift unit, then the frame check.
// A good frame then drains word by word (two frame-RAM reads, load, put).
// No new item is taken while a byte is in the bit-serial CRC loop; input stalls outside S_IDLE.
// Reset (synchronous, active low) clears control, counters, CRC and registers;
// the frame RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module modbus_rtu_reply_receiver #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_word_valid,
  output logic [15:0] out_reply_word,
  output logic        out_last
);

  import mrr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  // configuration registers
  logic [7:0]  dev_addr_r;
  logic [7:0]  cmd_code_r;
  logic [15:0] timeout_r;

  // sequencer and datapath state
  state_t        state_r, state_nxt;
  logic          rx_active_r, rx_active_nxt;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [15:0]   ticks_r, ticks_nxt;
  logic [2:0]    bit_cnt_r, bit_cnt_nxt;
  logic [7:0]    hdr0_r, hdr0_nxt;
  logic [7:0]    hdr1_r, hdr1_nxt;
  logic [7:0]    hdr2_r, hdr2_nxt;
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [6:0]    words_left_r, words_left_nxt;
  logic [7:0]    hi_r, hi_nxt;
  result_t       pend_r, pend_nxt;
  result_t       out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          in_acc;
  logic          out_acc;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [15:0]   tick_inc;
  logic          frame_done;
  logic          slot_free;

  mrr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(byte_count_r[AW-1:0]),
    .wdata(in_rx_byte),
    .raddr(rd_ptr_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign ram_we    = in_acc && (in_action == ACT_BYTE) && rx_active_r &&
                     (byte_count_r < CW'(BUFFER_DEPTH));
  assign tick_inc  = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 16'd1;

  assign frame_done = (byte_count_r > CW'(FRAME_OVERHEAD)) &&
                      (hdr0_r == dev_addr_r) && (hdr1_r == cmd_code_r) &&
                      (({1'b0, hdr2_r} + 9'(FRAME_OVERHEAD)) == 9'(byte_count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      cmd_code_r <= CMD_CODE_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEV_ADDR: dev_addr_r <= cfg_wdata[7:0];
        REG_CMD_CODE: cmd_code_r <= cfg_wdata[7:0];
        REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rx_active_nxt  = rx_active_r;
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    ticks_nxt      = ticks_r;
    bit_cnt_nxt    = bit_cnt_r;
    hdr0_nxt       = hdr0_r;
    hdr1_nxt       = hdr1_r;
    hdr2_nxt       = hdr2_r;
    rd_ptr_nxt     = rd_ptr_r;
    words_left_nxt = words_left_r;
    hi_nxt         = hi_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_acc;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_START: begin
              rx_active_nxt  = 1'b1;
              byte_count_nxt = '0;
              crc_nxt        = CRC_INIT;
              ticks_nxt      = '0;
            end
            ACT_BYTE: begin
              if (ram_we) begin
                if (byte_count_r == CW'(0)) hdr0_nxt = in_rx_byte;
                if (byte_count_r == CW'(1)) hdr1_nxt = in_rx_byte;
                if (byte_count_r == CW'(2)) hdr2_nxt = in_rx_byte;
                byte_count_nxt = byte_count_r + CW'(1);
                crc_nxt        = crc_r ^ {8'h00, in_rx_byte};
                bit_cnt_nxt    = '0;
                state_nxt      = S_CRC;
              end
            end
            ACT_TICK: begin
              if (rx_active_r) begin
                ticks_nxt = tick_inc;
                if (tick_inc >= timeout_r) begin
                  rx_active_nxt = 1'b0;
                  pend_nxt      = '{status: ST_TIMEOUT, word_valid: 1'b0,
                                    reply_word: 16'h0000, last: 1'b1};
                  state_nxt     = S_PUT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CRC: begin
        // one reflected CRC bit step per cycle
        crc_nxt     = {1'b0, crc_r[15:1]} ^ (crc_r[0] ? CRC_POLY : 16'h0000);
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
        if (frame_done) begin
          rx_active_nxt  = 1'b0;
          words_left_nxt = hdr2_r[7:1];
          rd_ptr_nxt     = CW'(3);
          if (crc_r != 16'h0000) begin
            pend_nxt  = '{status: ST_CRC_ERR, word_valid: 1'b0,
                          reply_word: 16'h0000, last: 1'b1};
            state_nxt = S_PUT;
          end else if (hdr2_r[7:1] == 7'd0) begin
            pend_nxt  = '{status: ST_OK, word_valid: 1'b0,
                          reply_word: 16'h0000, last: 1'b1};
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_RD_HI;
          end
        end
      end
      S_RD_HI: begin
        rd_ptr_nxt = rd_ptr_r + CW'(1);
        state_nxt  = S_RD_LO;
      end
      S_RD_LO: begin
        hi_nxt     = ram_rdata;
        rd_ptr_nxt = rd_ptr_r + CW'(1);
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        pend_nxt       = '{status: ST_OK, word_valid: 1'b1,
                           reply_word: {hi_r, ram_rdata},
                           last: (words_left_r == 7'd1)};
        words_left_nxt = words_left_r - 7'd1;
        state_nxt      = S_PUT;
      end
      S_PUT: begin
        // hold until the output register frees up
        if (slot_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pend_r.last ? S_IDLE : S_RD_HI;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rx_active_r  <= 1'b0;
      byte_count_r <= '0;
      crc_r        <= CRC_INIT;
      ticks_r      <= '0;
      bit_cnt_r    <= '0;
      words_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rx_active_r  <= rx_active_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      ticks_r      <= ticks_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      words_left_r <= words_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr0_r   <= hdr0_nxt;
    hdr1_r   <= hdr1_nxt;
    hdr2_r   <= hdr2_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    hi_r     <= hi_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_word_valid = out_r.word_valid;
  assign out_reply_word = out_r.reply_word;
  assign out_last       = out_r.last;

`ifndef SYNTHESIS
  a_crc_loop_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRC && bit_cnt_r == 3'd7) |=> (state_r == S_CHECK))
    else $error("CRC loop did not end after eight steps");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CW'(BUFFER_DEPTH))
    else $error("byte count past buffer depth");

  a_word_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.word_valid) |-> (out_r.status == ST_OK))
    else $error("data word carries a non-ok status");

  a_nonlast_is_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> out_r.word_valid)
    else $error("non-final result without a data word");

  a_drain_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_HI) |-> (words_left_r != 7'd0))
    else $error("frame read with no words left");
`endif

endmodule

// ----- src/mrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- test/modbus_rtu_reply_receiver_checker.sv -----
// Reply checker for the Modbus RTU reply receiver, with the CRC-16 helper it shares with the bench.
`timescale 1ns / 1ps

package mrr_tb_pkg;
  import mrr_pkg::*;

  // Fold one byte into a reflected CRC-16, LSB first
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction
endpackage

module modbus_rtu_reply_receiver_checker #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic        out_word_valid,
  input  logic [15:0] out_reply_word,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  import mrr_pkg::*;
  import mrr_tb_pkg::*;

  logic [7:0]  dev_addr;
  logic [7:0]  cmd_code;
  logic [15:0] tick_limit;
  logic        armed;
  int unsigned nbytes;
  logic [15:0] crc_acc;
  logic [15:0] ticks;
  logic [7:0]  frame_buf [BUFFER_DEPTH];
  result_t     pending_replies [$];
  result_t     want;
  int          n_fail = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic result_t make_reply(input logic [1:0] st, input logic wv,
                                         input logic [15:0] w, input logic l);
    result_t r;
    r.status = st;
    r.word_valid = wv;
    r.reply_word = w;
    r.last = l;
    return r;
  endfunction

  // Advance the receiver image by one item and queue the replies it causes
  task automatic predict_replies(input logic [1:0] act, input logic [7:0] b);
    int unsigned nwords;
    case (act)
      ACT_START: begin
        armed = 1'b1;
        nbytes = 0;
        crc_acc = CRC_INIT;
        ticks = '0;
      end
      ACT_TICK: begin
        if (armed) begin
          if (ticks != TICK_MAX) ticks = ticks + 16'd1;
          if (ticks >= tick_limit) begin
            armed = 1'b0;
            pending_replies.push_back(make_reply(ST_TIMEOUT, 1'b0, '0, 1'b1));
          end
        end
      end
      ACT_BYTE: begin
        // drop bytes while idle or past the end of the buffer
        if (armed && nbytes < BUFFER_DEPTH) begin
          frame_buf[nbytes] = b;
          nbytes++;
          crc_acc = crc16_fold(crc_acc, b);
          if (nbytes > FRAME_OVERHEAD && frame_buf[0] == dev_addr &&
              frame_buf[1] == cmd_code && frame_buf[2] + FRAME_OVERHEAD == nbytes) begin
            armed = 1'b0;
            nwords = frame_buf[2] >> 1;
            if (crc_acc != 16'h0000) begin
              pending_replies.push_back(make_reply(ST_CRC_ERR, 1'b0, '0, 1'b1));
            end else if (nwords == 0) begin
              pending_replies.push_back(make_reply(ST_OK, 1'b0, '0, 1'b1));
            end else begin
              // odd trailing data byte is covered by the CRC but never output
              for (int unsigned j = 0; j < nwords; j++) begin
                pending_replies.push_back(make_reply(ST_OK, 1'b1,
                    {frame_buf[3 + 2 * j], frame_buf[4 + 2 * j]}, j + 1 == nwords));
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dev_addr = DEV_ADDR_RST;
      cmd_code = CMD_CODE_RST;
      tick_limit = TIMEOUT_RST;
      armed = 1'b0;
      nbytes = 0;
      crc_acc = CRC_INIT;
      ticks = '0;
      pending_replies.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_DEV_ADDR: dev_addr = cfg_wdata[7:0];
          REG_CMD_CODE: cmd_code = cfg_wdata[7:0];
          REG_TIMEOUT:  tick_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) predict_replies(in_action, in_rx_byte);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected reply: status %0d word_valid %0d reply_word 0x%04h last %0d",
                 out_status, out_word_valid, out_reply_word, out_last);
          n_fail++;
        end else begin
          want = pending_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            n_fail++;
          end
          if (out_word_valid !== want.word_valid) begin
            $error("word_valid mismatch: expected %0d, actual %0d",
                   want.word_valid, out_word_valid);
            n_fail++;
          end
          if (out_reply_word !== want.reply_word) begin
            $error("reply_word mismatch: expected 0x%04h, actual 0x%04h",
                   want.reply_word, out_reply_word);
            n_fail++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
            n_fail++;
          end
        end
      end
    end
    pending <= pending_replies.size();
    fail_count <= n_fail;
  end

endmodule

// ----- test/modbus_rtu_reply_receiver_tb.sv -----
// Stimulus and verdict for the Modbus RTU reply receiver bench.
`timescale 1ns / 1ps

module modbus_rtu_reply_receiver_tb;
  import mrr_pkg::*;
  import mrr_tb_pkg::*;

  localparam int BUFFER_DEPTH = 64;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_word_valid;
  logic [15:0] out_reply_word;
  logic        out_last;

  int          fail_count;
  int          pending;
  int          src_idle_pct = 23;
  int          sink_idle_pct = 59;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  logic [7:0]  cur_addr = DEV_ADDR_RST;
  logic [7:0]  cur_cmd = CMD_CODE_RST;
  logic [15:0] cur_timeout = TIMEOUT_RST;
  logic [7:0]  frame_bytes [$];

  modbus_rtu_reply_receiver #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_word_valid(out_word_valid), .out_reply_word(out_reply_word), .out_last(out_last)
  );

  modbus_rtu_reply_receiver_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_word_valid(out_word_valid), .out_reply_word(out_reply_word), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("modbus_rtu_reply_receiver_tb NOT OK");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_item(input logic [1:0] act, input logic [7:0] b, input bit tally);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      in_action <= 2'($urandom);
      in_rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (tally) items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [15:0] tmo);
    write_reg(REG_DEV_ADDR, {8'($urandom), addr});
    write_reg(REG_CMD_CODE, {8'($urandom), cmd});
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
    cur_addr = addr;
    cur_cmd = cmd;
    cur_timeout = tmo;
  endtask

  // Wait until every reply is in, then let a byte still in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic begin_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input int count, input int ndata);
    frame_bytes.delete();
    frame_bytes.push_back(addr);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(8'(count));
    repeat (ndata) frame_bytes.push_back(8'($urandom));
  endtask

  // Append the CRC, low byte first, so a clean frame leaves a zero residue
  task automatic seal_frame();
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = crc16_fold(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
  endtask

  task automatic flip_bit(input int lo);
    int idx;
    idx = $urandom_range(frame_bytes.size() - 1, lo);
    frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
  endtask

  task automatic transmit_frame(input int tick_pct, input int nsend);
    send_item(ACT_START, 8'($urandom), 1'b1);
    for (int i = 0; i < nsend && i < frame_bytes.size(); i++) begin
      if ($urandom_range(99) < tick_pct) send_item(ACT_TICK, 8'($urandom), 1'b1);
      send_item(ACT_BYTE, frame_bytes[i], 1'b1);
    end
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int pick;
    int n;
    int nt;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        n = $urandom_range(8, 1);
        begin_frame(cur_addr, cur_cmd, n, n);
        seal_frame();
        transmit_frame(3, frame_bytes.size());
      end else if (pick < 68) begin
        n = $urandom_range(8, 1);
        begin_frame(cur_addr, cur_cmd, n, n);
        seal_frame();
        flip_bit(3);
        transmit_frame(3, frame_bytes.size());
      end else if (pick < 76) begin
        // wrong address or function code: never completes
        n = $urandom_range(6, 1);
        begin_frame(cur_addr, cur_cmd, n, n);
        seal_frame();
        nt = $urandom_range(1);
        frame_bytes[nt] = frame_bytes[nt] ^ (8'h01 << $urandom_range(7));
        transmit_frame(3, frame_bytes.size());
      end else if (pick < 85) begin
        n = $urandom_range(10, 2);
        begin_frame(cur_addr, cur_cmd, n, n);
        seal_frame();
        transmit_frame(0, $urandom_range(4));
        if (cur_timeout <= 40) nt = cur_timeout + $urandom_range(2);
        else nt = $urandom_range(5, 1);
        repeat (nt) send_item(ACT_TICK, 8'($urandom), 1'b1);
      end else if (pick < 89) begin
        n = $urandom_range(BUFFER_DEPTH - FRAME_OVERHEAD, 20);
        begin_frame(cur_addr, cur_cmd, n, n);
        seal_frame();
        transmit_frame(2, frame_bytes.size());
      end else if (pick < 91) begin
        // count too large to fit: overrun the buffer
        begin_frame(cur_addr, cur_cmd, $urandom_range(255, BUFFER_DEPTH - 4),
                    BUFFER_DEPTH - 3 + $urandom_range(5));
        seal_frame();
        transmit_frame(0, frame_bytes.size());
      end else begin
        repeat ($urandom_range(6, 1)) send_item(2'($urandom), 8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ignored items: byte and tick while idle, unused action
    send_item(ACT_BYTE, 8'hFF, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b0);
    send_item(ACT_NONE, 8'h5A, 1'b0);
    // restart mid-frame, then one word with extreme bytes
    send_item(ACT_START, 8'h00, 1'b1);
    send_item(ACT_BYTE, DEV_ADDR_RST, 1'b1);
    begin_frame(DEV_ADDR_RST, CMD_CODE_RST, 8'd2, 0);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    seal_frame();
    transmit_frame(0, frame_bytes.size());
    // odd length with no whole word
    begin_frame(DEV_ADDR_RST, CMD_CODE_RST, 8'd1, 0);
    frame_bytes.push_back(8'h00);
    seal_frame();
    transmit_frame(0, frame_bytes.size());
    // corrupted frame
    begin_frame(DEV_ADDR_RST, CMD_CODE_RST, 8'd1, 1);
    seal_frame();
    flip_bit(3);
    transmit_frame(0, frame_bytes.size());
    settle();
    // zero timeout: first tick gives up
    set_config(DEV_ADDR_RST, CMD_CODE_RST, 16'd0);
    send_item(ACT_START, 8'h00, 1'b1);
    send_item(ACT_TICK, 8'hFF, 1'b1);
    settle();

    set_config(8'h00, 8'hFF, 16'd5);
    begin_frame(cur_addr, cur_cmd, BUFFER_DEPTH - FRAME_OVERHEAD, BUFFER_DEPTH - FRAME_OVERHEAD);
    seal_frame();
    transmit_frame(0, frame_bytes.size());
    begin_frame(cur_addr, cur_cmd, 8'hFF, BUFFER_DEPTH);
    seal_frame();
    transmit_frame(0, frame_bytes.size());
    run_random(100);
    settle();

    src_idle_pct = 59;
    sink_idle_pct = 23;
    set_config(8'hFF, 8'h00, 16'hFFFF);
    run_random(100);
    settle();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(20, 1)));
    run_random(100);
    settle();

    if (fail_count == 0) begin
      $display("modbus_rtu_reply_receiver_tb OK");
    end else begin
      $display("modbus_rtu_reply_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule
